// ----- src/tgk_pkg.sv -----
// Shared constants and types for the transmit gate keying block.
package tgk_pkg;

   // Field widths.
   localparam int unsigned WORD_WIDTH  = 16;
   localparam int unsigned TIME_WIDTH  = 32;
   localparam int unsigned ROOM_WIDTH  = 4;
   localparam int unsigned STATE_WIDTH = 3;
   localparam int unsigned CSR_WIDTH   = 16;

   // Preamble geometry.
   localparam int unsigned PREAMBLE_LEN = 8;
   localparam int unsigned BEAT_WIDTH   = $clog2(PREAMBLE_LEN);

   // Register indexes on the configuration port.
   localparam logic CSR_KEY_UP_WAIT = 1'b0;
   localparam logic CSR_IDLE_LIMIT  = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [CSR_WIDTH-1:0] KEY_UP_WAIT_RESET = 16'd50;
   localparam logic [CSR_WIDTH-1:0] IDLE_LIMIT_RESET  = 16'd10;

   typedef logic [WORD_WIDTH-1:0] word_type;

   // Fixed preamble word sequence.
   function automatic word_type preamble_word(input logic [BEAT_WIDTH-1:0] beat);
      word_type word;
      unique case (beat)
         3'd0:    word = 16'd45295;
         3'd1:    word = 16'd60807;
         3'd2:    word = 16'd26305;
         3'd3:    word = 16'd46268;
         3'd4:    word = 16'd45295;
         3'd5:    word = 16'd60807;
         3'd6:    word = 16'd45295;
         3'd7:    word = 16'd60807;
         default: word = '0;
      endcase
      return word;
   endfunction

endpackage

// ----- src/transmit_gate_keying_fsm_core.sv -----
// Transmit gate keying state machine with push-to-talk and preamble insertion.
//
// Each request transfer is one scheduler pass and is answered by one response
// transfer, except the pass that starts transmission, which is answered by the
// eight preamble words on eight consecutive response transfers. A request is
// held in an input register and evaluated combinationally into the response
// register, so one pass per cycle is sustained while the response side keeps
// up; while empty, the input register takes a new request even while a
// response is stalled. During the preamble the response register is busy
// with the remaining beats and the request side stalls once its input register
// is full. Configuration writes are expected only while no pass is in flight.
module transmit_gate_keying_fsm_core (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_has_input,
   input  logic [tgk_pkg::WORD_WIDTH-1:0]   req_input_word,
   input  logic [tgk_pkg::ROOM_WIDTH-1:0]   req_out_room,
   input  logic                             req_pipeline_idle,
   input  logic                             req_downstream_empty,
   input  logic [tgk_pkg::TIME_WIDTH-1:0]   req_now_ms,
   // Response channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tgk_pkg::WORD_WIDTH-1:0]   rsp_out_word,
   output logic                             rsp_word_valid,
   output logic                             rsp_last_of_run,
   output logic                             rsp_consumed,
   output logic                             rsp_ptt_request,
   output logic [tgk_pkg::STATE_WIDTH-1:0]  rsp_gate_state,
   // Configuration port.
   input  logic                             csr_write_enable,
   input  logic                             csr_index,
   input  logic [tgk_pkg::CSR_WIDTH-1:0]    csr_write_data
);
   import tgk_pkg::*;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_RECEIVE      = 3'd0,
      ST_TO_RECEIVE   = 3'd1,
      ST_TO_TRANSMIT  = 3'd2,
      ST_TRANSMIT     = 3'd3,
      ST_END          = 3'd4,
      ST_WAIT_RECEIVE = 3'd5
   } phase_type;

   // Configuration registers.
   logic [CSR_WIDTH-1:0]  key_up_wait_ff;
   logic [CSR_WIDTH-1:0]  idle_limit_ff;

   // Gate state.
   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] key_start_ff, key_start_in;
   logic [15:0]           idle_count_ff, idle_count_in;

   // Input register.
   logic                  in_valid_ff;
   logic                  in_has_input_ff;
   word_type              in_word_ff;
   logic [ROOM_WIDTH-1:0] in_room_ff;
   logic                  in_pipe_idle_ff;
   logic                  in_ds_empty_ff;
   logic [TIME_WIDTH-1:0] in_now_ff;

   // Response register and preamble sequencing.
   logic                  rsp_valid_ff;
   word_type              rsp_word_ff;
   logic                  rsp_word_valid_ff;
   logic                  rsp_last_ff;
   logic                  rsp_consumed_ff;
   logic                  rsp_ptt_ff;
   phase_type             rsp_state_ff;
   logic                  burst_ff;
   logic [BEAT_WIDTH-1:0] beat_ff;

   // Result of evaluating the held pass.
   word_type              step_word;
   logic                  step_word_valid;
   logic                  step_consumed;
   logic                  step_ptt;
   logic                  step_preamble;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  room_ok;

   logic                  rsp_load;
   logic                  step_fire;
   logic                  in_take;

   // The response register can load when empty or when its content leaves.
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign step_fire = rsp_load && in_valid_ff && !burst_ff;
   assign req_stall = in_valid_ff && !step_fire;
   assign in_take   = req_valid && !req_stall;

   assign elapsed = in_now_ff - key_start_ff;
   assign room_ok = in_room_ff >= ROOM_WIDTH'(PREAMBLE_LEN);

   // One pass of the gate.
   always_comb begin
      phase_in        = phase_ff;
      key_start_in    = key_start_ff;
      idle_count_in   = idle_count_ff;
      step_word       = '0;
      step_word_valid = 1'b0;
      step_consumed   = 1'b0;
      step_ptt        = 1'b0;
      step_preamble   = 1'b0;
      unique case (phase_ff)
         ST_RECEIVE, ST_TO_RECEIVE: begin
            if (in_has_input_ff) begin
               phase_in     = ST_TO_TRANSMIT;
               key_start_in = in_now_ff;
               step_ptt     = 1'b1;
            end
         end
         ST_TO_TRANSMIT: begin
            if ((elapsed > TIME_WIDTH'(key_up_wait_ff)) && room_ok) begin
               phase_in        = ST_TRANSMIT;
               step_preamble   = 1'b1;
               step_word       = preamble_word('0);
               step_word_valid = 1'b1;
               step_consumed   = 1'b1;
            end
         end
         ST_TRANSMIT: begin
            if (in_has_input_ff) begin
               step_consumed = 1'b1;
               if (in_room_ff != '0) begin
                  step_word       = in_word_ff;
                  step_word_valid = 1'b1;
               end
            end else if (in_pipe_idle_ff && in_ds_empty_ff) begin
               idle_count_in = idle_count_ff + 16'd1;
               if (idle_count_ff > idle_limit_ff) begin
                  idle_count_in   = '0;
                  phase_in        = ST_END;
                  step_word_valid = 1'b1;
                  step_consumed   = 1'b1;
               end
            end
         end
         ST_END: begin
            if (in_ds_empty_ff) begin
               key_start_in = in_now_ff;
               phase_in     = ST_WAIT_RECEIVE;
            end
         end
         default: begin
         end
      endcase
   end

   // Configuration, gate state, input register and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_up_wait_ff <= KEY_UP_WAIT_RESET;
         idle_limit_ff  <= IDLE_LIMIT_RESET;
         phase_ff       <= ST_RECEIVE;
         key_start_ff   <= '0;
         idle_count_ff  <= '0;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         burst_ff       <= 1'b0;
         beat_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_KEY_UP_WAIT: key_up_wait_ff <= csr_write_data;
               CSR_IDLE_LIMIT:  idle_limit_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end

         // Input register fills on a request transfer and drains on evaluation.
         if (in_take) begin
            in_valid_ff <= 1'b1;
         end else if (step_fire) begin
            in_valid_ff <= 1'b0;
         end

         // Response register: preamble beats first, then evaluated passes.
         if (rsp_load) begin
            if (burst_ff) begin
               rsp_valid_ff <= 1'b1;
               beat_ff      <= beat_ff + 1'b1;
               if (beat_ff == BEAT_WIDTH'(PREAMBLE_LEN - 1)) begin
                  burst_ff <= 1'b0;
               end
            end else if (in_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               phase_ff      <= phase_in;
               key_start_ff  <= key_start_in;
               idle_count_ff <= idle_count_in;
               burst_ff      <= step_preamble;
               beat_ff       <= BEAT_WIDTH'(1);
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_has_input_ff <= req_has_input;
         in_word_ff      <= req_input_word;
         in_room_ff      <= req_out_room;
         in_pipe_idle_ff <= req_pipeline_idle;
         in_ds_empty_ff  <= req_downstream_empty;
         in_now_ff       <= req_now_ms;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (burst_ff) begin
            rsp_word_ff       <= preamble_word(beat_ff);
            rsp_word_valid_ff <= 1'b1;
            rsp_last_ff       <= (beat_ff == BEAT_WIDTH'(PREAMBLE_LEN - 1));
            rsp_consumed_ff   <= 1'b1;
            rsp_ptt_ff        <= 1'b0;
         end else if (in_valid_ff) begin
            rsp_word_ff       <= step_word;
            rsp_word_valid_ff <= step_word_valid;
            rsp_last_ff       <= !step_preamble;
            rsp_consumed_ff   <= step_consumed;
            rsp_ptt_ff        <= step_ptt;
            rsp_state_ff      <= phase_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_word    = rsp_word_ff;
   assign rsp_word_valid  = rsp_word_valid_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_consumed    = rsp_consumed_ff;
   assign rsp_ptt_request = rsp_ptt_ff;
   assign rsp_gate_state  = rsp_state_ff;

   // A preamble in progress always has a response on the channel.
   assert property (@(posedge clock) disable iff (reset) burst_ff |-> rsp_valid_ff)
      else $error("preamble sequencing without a response held");

   // Keying responses move to the key-up wait and never consume the word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ptt_ff) |->
         (rsp_state_ff == ST_TO_TRANSMIT) && !rsp_consumed_ff && !rsp_word_valid_ff)
      else $error("keying response with wrong fields");

   // A response that is not last of its run is followed by the next preamble beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !rsp_last_ff) |=> (rsp_valid_ff && rsp_word_valid_ff))
      else $error("preamble run broken");

   // No new pass is evaluated while the preamble is still being sent.
   assert property (@(posedge clock) disable iff (reset)
      burst_ff |-> !step_fire)
      else $error("pass evaluated during preamble");

endmodule

// ----- tb/sv/transmit_gate_keying_fsm_core_tb.sv -----
// Self-checking testbench for the transmit gate keying state machine.
`timescale 1ns / 1ps

module transmit_gate_keying_fsm_core_tb;
   import tgk_pkg::*;

   // Gate states as they appear on the response channel.
   typedef enum logic [STATE_WIDTH-1:0] {
      GATE_RECEIVE      = 3'd0,
      GATE_TO_RECEIVE   = 3'd1,
      GATE_TO_TRANSMIT  = 3'd2,
      GATE_TRANSMIT     = 3'd3,
      GATE_END          = 3'd4,
      GATE_WAIT_RECEIVE = 3'd5
   } gate_state_type;

   // One scheduler pass on the request channel.
   typedef struct packed {
      logic                  has_input;
      word_type              input_word;
      logic [ROOM_WIDTH-1:0] out_room;
      logic                  pipeline_idle;
      logic                  downstream_empty;
      logic [TIME_WIDTH-1:0] now_ms;
   } pass_type;

   // One transfer on the response channel.
   typedef struct packed {
      word_type       out_word;
      logic           word_valid;
      logic           last_of_run;
      logic           consumed;
      logic           ptt_request;
      gate_state_type gate_state;
   } reply_type;

   // A directed row: the pass, and a hand-written reply where one is given.
   typedef struct {
      pass_type  pass;
      logic      typed;
      reply_type want;
   } plan_row_type;

   localparam int NUM_PLAN_ROWS = 15;
   localparam int MAX_SHOWN     = 10;
   localparam word_type PREAMBLE_WORDS [PREAMBLE_LEN] = '{
      16'd45295, 16'd60807, 16'd26305, 16'd46268,
      16'd45295, 16'd60807, 16'd45295, 16'd60807
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_has_input;
   logic [WORD_WIDTH-1:0]  req_input_word;
   logic [ROOM_WIDTH-1:0]  req_out_room;
   logic                   req_pipeline_idle;
   logic                   req_downstream_empty;
   logic [TIME_WIDTH-1:0]  req_now_ms;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [WORD_WIDTH-1:0]  rsp_out_word;
   logic                   rsp_word_valid;
   logic                   rsp_last_of_run;
   logic                   rsp_consumed;
   logic                   rsp_ptt_request;
   logic [STATE_WIDTH-1:0] rsp_gate_state;
   logic                   csr_write_enable;
   logic                   csr_index;
   logic [CSR_WIDTH-1:0]   csr_write_data;

   // Shadow copy of the gate state and its registers.
   gate_state_type        gate_phase;
   logic [TIME_WIDTH-1:0] key_time;
   logic [15:0]           idle_passes;
   logic [CSR_WIDTH-1:0]  key_wait_ms;
   logic [CSR_WIDTH-1:0]  idle_limit;

   reply_type    gate_replies [$];
   plan_row_type plan [NUM_PLAN_ROWS];
   int           mismatch_count;
   int           send_gap_pct;
   int           recv_stall_pct;

   transmit_gate_keying_fsm_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_has_input        (req_has_input),
      .req_input_word       (req_input_word),
      .req_out_room         (req_out_room),
      .req_pipeline_idle    (req_pipeline_idle),
      .req_downstream_empty (req_downstream_empty),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_word         (rsp_out_word),
      .rsp_word_valid       (rsp_word_valid),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_consumed         (rsp_consumed),
      .rsp_ptt_request      (rsp_ptt_request),
      .rsp_gate_state       (rsp_gate_state),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the replies of one pass and advance the shadow state.
   function automatic void run_gate_pass(input pass_type p, ref reply_type replies[$]);
      reply_type             r;
      logic [TIME_WIDTH-1:0] elapsed;
      logic [15:0]           old_count;
      r = '0;
      r.last_of_run = 1'b1;
      elapsed = p.now_ms - key_time;
      case (gate_phase)
         GATE_RECEIVE, GATE_TO_RECEIVE: begin
            if (p.has_input) begin
               gate_phase = GATE_TO_TRANSMIT;
               key_time = p.now_ms;
               r.ptt_request = 1'b1;
            end
         end
         GATE_TO_TRANSMIT: begin
            if (elapsed > {16'd0, key_wait_ms} &&
                p.out_room >= ROOM_WIDTH'(PREAMBLE_LEN)) begin
               gate_phase = GATE_TRANSMIT;
               for (int k = 0; k < PREAMBLE_LEN; k++) begin
                  r.out_word    = PREAMBLE_WORDS[k];
                  r.word_valid  = 1'b1;
                  r.last_of_run = (k == PREAMBLE_LEN - 1);
                  r.consumed    = 1'b1;
                  r.gate_state  = gate_phase;
                  replies.push_back(r);
               end
               return;
            end
         end
         GATE_TRANSMIT: begin
            if (p.has_input) begin
               // A word passes only when there is room for it.
               r.consumed = 1'b1;
               if (p.out_room != 0) begin
                  r.out_word   = p.input_word;
                  r.word_valid = 1'b1;
               end
            end else if (p.pipeline_idle && p.downstream_empty) begin
               old_count = idle_passes;
               idle_passes = idle_passes + 16'd1;
               if (old_count > idle_limit) begin
                  idle_passes  = '0;
                  gate_phase   = GATE_END;
                  r.word_valid = 1'b1;
                  r.consumed   = 1'b1;
               end
            end
         end
         GATE_END: begin
            if (p.downstream_empty) begin
               key_time = p.now_ms;
               gate_phase = GATE_WAIT_RECEIVE;
            end
         end
         default: ;
      endcase
      r.gate_state = gate_phase;
      replies.push_back(r);
   endfunction

   // Random pass; with keep_busy set it never counts as an idle pass.
   function automatic pass_type random_pass(input bit keep_busy);
      pass_type p;
      p.has_input        = ($urandom_range(99) < 55);
      p.input_word       = WORD_WIDTH'($urandom);
      p.out_room         = ROOM_WIDTH'($urandom_range(15));
      p.pipeline_idle    = 1'($urandom_range(1));
      p.downstream_empty = 1'($urandom_range(1));
      p.now_ms           = $urandom;
      if (keep_busy && !p.has_input) begin
         p.pipeline_idle = 1'b0;
      end
      return p;
   endfunction

   // Offer one pass and queue its replies once the transfer happens.
   task automatic offer_pass(input pass_type p, input logic typed, input reply_type want);
      reply_type replies [$];
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_has_input        <= p.has_input;
      req_input_word       <= p.input_word;
      req_out_room         <= p.out_room;
      req_pipeline_idle    <= p.pipeline_idle;
      req_downstream_empty <= p.downstream_empty;
      req_now_ms           <= p.now_ms;
      do @(posedge clock); while (req_stall);
      run_gate_pass(p, replies);
      if (typed) begin
         gate_replies.push_back(want);
      end else begin
         foreach (replies[i]) gate_replies.push_back(replies[i]);
      end
   endtask

   // Stop offering and let every queued reply come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (gate_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers on consecutive cycles while the gate is quiet.
   task automatic program_gate(input logic [CSR_WIDTH-1:0] wait_ms,
                               input logic [CSR_WIDTH-1:0] limit);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_KEY_UP_WAIT;
      csr_write_data   <= wait_ms;
      @(posedge clock);
      csr_index        <= CSR_IDLE_LIMIT;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      key_wait_ms = wait_ms;
      idle_limit  = limit;
   endtask

   task automatic flag_mismatch(input string why, input reply_type want, input reply_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
         $display("%0t: %s: expected word=%h valid=%b last=%b consumed=%b ptt=%b state=%0d",
                  $realtime, why, want.out_word, want.word_valid, want.last_of_run,
                  want.consumed, want.ptt_request, want.gate_state);
         $display("%0t: %s: actual   word=%h valid=%b last=%b consumed=%b ptt=%b state=%0d",
                  $realtime, why, got.out_word, got.word_valid, got.last_of_run,
                  got.consumed, got.ptt_request, got.gate_state);
      end
   endtask

   // Response side: random stalls and the check of each transfer.
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_word, rsp_word_valid, rsp_last_of_run, rsp_consumed,
                   rsp_ptt_request, gate_state_type'(rsp_gate_state)};
            if (gate_replies.size() == 0) begin
               flag_mismatch("unexpected transfer", '0, got);
            end else begin
               want = gate_replies.pop_front();
               if (got !== want) flag_mismatch("reply mismatch", want, got);
            end
         end
      end
   end

   // Stimulus: directed walk from receive through transmit, then random phases.
   initial begin
      mismatch_count = 0;
      send_gap_pct   = 27;
      recv_stall_pct = 62;
      gate_phase     = GATE_RECEIVE;
      key_time       = '0;
      idle_passes    = '0;
      key_wait_ms    = KEY_UP_WAIT_RESET;
      idle_limit     = IDLE_LIMIT_RESET;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_has_input        <= 1'b0;
      req_input_word       <= '0;
      req_out_room         <= '0;
      req_pipeline_idle    <= 1'b0;
      req_downstream_empty <= 1'b0;
      req_now_ms           <= '0;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_KEY_UP_WAIT;
      csr_write_data       <= '0;

      plan = '{
         // Receive with no word offered stays in receive.
         '{'{1'b0, 16'hFFFF, 4'd0, 1'b1, 1'b1, 32'h0000_0000}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, GATE_RECEIVE}},
         '{'{1'b0, 16'h0000, 4'd15, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, GATE_RECEIVE}},
         // Keying pass: the word is not taken.
         '{'{1'b1, 16'hA5A5, 4'd0, 1'b0, 1'b0, 32'hFFFF_0000}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b1, GATE_TO_TRANSMIT}},
         // Elapsed time equal to the wait is not yet enough.
         '{'{1'b1, 16'h1111, 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, GATE_TO_TRANSMIT}},
         // Time has wrapped past the wait, but room is one short.
         '{'{1'b0, 16'h2222, 4'd7, 1'b1, 1'b1, 32'h0000_0000}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, GATE_TO_TRANSMIT}},
         // Room of eight or more starts the preamble.
         '{'{1'b1, 16'h1234, 4'd15, 1'b0, 1'b1, 32'h0000_0000}, 1'b0, '0},
         // Pass-through at the word extremes, then with no room.
         '{'{1'b1, 16'hFFFF, 4'd1, 1'b0, 1'b0, 32'h1234_5678}, 1'b1,
           '{16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, GATE_TRANSMIT}},
         '{'{1'b1, 16'h0000, 4'd8, 1'b1, 1'b1, 32'h8000_0000}, 1'b1,
           '{16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, GATE_TRANSMIT}},
         '{'{1'b1, 16'h5A5A, 4'd0, 1'b1, 1'b1, 32'h7FFF_FFFF}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b1, 1'b0, GATE_TRANSMIT}},
         // Idle pass below the limit, then busy pipeline and busy downstream.
         '{'{1'b0, 16'hFFFF, 4'd15, 1'b1, 1'b1, 32'h0000_0001}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, GATE_TRANSMIT}},
         '{'{1'b0, 16'h0000, 4'd15, 1'b0, 1'b1, 32'h0000_0002}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, GATE_TRANSMIT}},
         '{'{1'b0, 16'h0000, 4'd15, 1'b1, 1'b0, 32'h0000_0003}, 1'b1,
           '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, GATE_TRANSMIT}},
         '{'{1'b1, 16'h8000, 4'd15, 1'b0, 1'b0, 32'hDEAD_BEEF}, 1'b0, '0},
         '{'{1'b0, 16'h7FFF, 4'd0, 1'b1, 1'b1, 32'h0F0F_0F0F}, 1'b0, '0},
         '{'{1'b1, 16'h0001, 4'd9, 1'b1, 1'b1, 32'hF0F0_F0F0}, 1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Longest wait and a limit that never ends the transmission.
      program_gate(16'hFFFF, 16'hFFFF);
      foreach (plan[i]) offer_pass(plan[i].pass, plan[i].typed, plan[i].want);

      // Random transmit traffic, sender idling less than the receiver.
      drain_replies();
      program_gate(16'h0000, 16'($urandom_range(65534, 1000)));
      repeat (110) offer_pass(random_pass(1'b0), 1'b0, '0);

      // The other way round, back at the largest limit.
      drain_replies();
      send_gap_pct   = 62;
      recv_stall_pct = 27;
      program_gate(16'($urandom_range(65535)), 16'hFFFF);
      repeat (110) offer_pass(random_pass(1'b0), 1'b0, '0);

      // Limit equal to the current count: the second idle pass ends it.
      drain_replies();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      program_gate(16'($urandom), idle_passes);
      repeat (80) offer_pass(random_pass(1'b1), 1'b0, '0);
      repeat (45) offer_pass(random_pass(1'b0), 1'b0, '0);

      // Zero limit once the gate rests in wait-receive.
      drain_replies();
      program_gate(16'($urandom), 16'h0000);
      repeat (20) offer_pass(random_pass(1'b0), 1'b0, '0);

      drain_replies();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && gate_replies.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
